/* src/labelled_sensor_frame_parser_top_assert.svh */
// Assertion macros for the labelled sensor frame parser.
`ifndef LABELLED_SENSOR_FRAME_PARSER_TOP_ASSERT_SVH
`define LABELLED_SENSOR_FRAME_PARSER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Check a property on every clock edge outside reset.
`define LSFP_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("lsfp assertion failed");

// Check a property on every clock edge, reset included.
`define LSFP_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("lsfp assertion failed during or after reset");

`else

`define LSFP_ASSERT(name, prop)
`define LSFP_ASSERT_ALWAYS(name, prop)

`endif

`endif

/* src/lsfp_pkg.sv */
package lsfp_pkg;

  localparam int unsigned VAL_W = 31;
  localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_HASH   = 8'h23;
  localparam logic [7:0] CHAR_T      = 8'h54;
  localparam logic [7:0] CHAR_H      = 8'h48;
  localparam logic [7:0] CHAR_P      = 8'h50;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;

  typedef enum logic [1:0] {
    CH_TEMP  = 2'd0,
    CH_HUMID = 2'd1,
    CH_PRESS = 2'd2
  } channel_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_START = 2'd1,
    PH_LABEL = 2'd2
  } phase_t;

  typedef struct packed {
    logic       is_start;
    logic       is_end;
    logic       is_label;
    channel_t   label_code;
    logic       is_digit;
    logic [3:0] digit;
  } byte_class_t;

  typedef struct packed {
    logic             emit;
    channel_t         channel;
    logic [VAL_W-1:0] frame_value;
    logic [VAL_W-1:0] held_temperature;
    logic [VAL_W-1:0] held_humidity;
    logic [VAL_W-1:0] held_pressure;
  } result_t;

endpackage

/* src/lsfp_classify.sv */
module lsfp_classify (
  input  logic [7:0]                rx_byte,
  output lsfp_pkg::byte_class_t     cls
);

  always_comb begin
    cls.is_start = (rx_byte == lsfp_pkg::CHAR_DOLLAR);
    cls.is_end   = (rx_byte == lsfp_pkg::CHAR_HASH);
    cls.is_label = (rx_byte == lsfp_pkg::CHAR_T) || (rx_byte == lsfp_pkg::CHAR_H) ||
                   (rx_byte == lsfp_pkg::CHAR_P);
    if (rx_byte == lsfp_pkg::CHAR_T) begin
      cls.label_code = lsfp_pkg::CH_TEMP;
    end else if (rx_byte == lsfp_pkg::CHAR_H) begin
      cls.label_code = lsfp_pkg::CH_HUMID;
    end else begin
      cls.label_code = lsfp_pkg::CH_PRESS;
    end
    cls.is_digit = (rx_byte >= lsfp_pkg::CHAR_ZERO) && (rx_byte <= lsfp_pkg::CHAR_NINE);
    // ASCII digits sit at 0x30..0x39, so the low nibble is the digit value
    cls.digit    = rx_byte[3:0];
  end

endmodule

/* src/lsfp_frame_fsm.sv */
module lsfp_frame_fsm (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  lsfp_pkg::byte_class_t cls,
  output lsfp_pkg::result_t     res
);

  localparam int unsigned VW = lsfp_pkg::VAL_W;
  localparam int unsigned PW = VW + 4;

  lsfp_pkg::phase_t   phase, phase_next;
  logic               label_seen, label_seen_next;
  lsfp_pkg::channel_t label_code, label_code_next;
  logic [VW-1:0]      accumulator, accumulator_next;
  logic [VW-1:0]      temperature_reading, temperature_reading_next;
  logic [VW-1:0]      humidity_reading, humidity_reading_next;
  logic [VW-1:0]      pressure_reading, pressure_reading_next;

  logic [PW-1:0]      acc_x10;
  logic [VW-1:0]      acc_sat;
  logic               in_frame;

  // value*10 + digit as (value<<3) + (value<<1) + digit
  assign acc_x10 = {1'b0, accumulator, 3'b000} + {3'b000, accumulator, 1'b0} +
                   {{(PW-4){1'b0}}, cls.digit};
  assign acc_sat = (acc_x10[PW-1:VW] != '0) ? lsfp_pkg::VAL_MAX : acc_x10[VW-1:0];
  assign in_frame = (phase == lsfp_pkg::PH_START) || (phase == lsfp_pkg::PH_LABEL);

  // next phase
  always_comb begin
    phase_next = phase;
    if (cls.is_start) begin
      phase_next = lsfp_pkg::PH_START;
    end else if (cls.is_end) begin
      phase_next = lsfp_pkg::PH_IDLE;
    end else begin
      case (phase)
        lsfp_pkg::PH_START: begin
          if (cls.is_label) begin
            phase_next = lsfp_pkg::PH_LABEL;
          end
        end
        lsfp_pkg::PH_LABEL: phase_next = lsfp_pkg::PH_LABEL;
        default:            phase_next = lsfp_pkg::PH_IDLE;
      endcase
    end
  end

  // datapath and result
  always_comb begin
    label_seen_next          = label_seen;
    label_code_next          = label_code;
    accumulator_next         = accumulator;
    temperature_reading_next = temperature_reading;
    humidity_reading_next    = humidity_reading;
    pressure_reading_next    = pressure_reading;
    res.emit                 = 1'b0;
    if (cls.is_start) begin
      label_seen_next  = 1'b0;
      label_code_next  = lsfp_pkg::CH_TEMP;
      accumulator_next = '0;
    end else if (cls.is_end) begin
      res.emit = in_frame && label_seen;
      if (res.emit) begin
        case (label_code)
          lsfp_pkg::CH_TEMP:  temperature_reading_next = accumulator;
          lsfp_pkg::CH_HUMID: humidity_reading_next    = accumulator;
          default:            pressure_reading_next    = accumulator;
        endcase
      end
    end else begin
      case (phase)
        lsfp_pkg::PH_START: begin
          if (cls.is_label) begin
            label_seen_next = 1'b1;
            label_code_next = cls.label_code;
          end
        end
        lsfp_pkg::PH_LABEL: begin
          if (cls.is_digit) begin
            accumulator_next = acc_sat;
          end
        end
        default: ;
      endcase
    end
    res.channel          = label_code;
    res.frame_value      = accumulator;
    res.held_temperature = temperature_reading_next;
    res.held_humidity    = humidity_reading_next;
    res.held_pressure    = pressure_reading_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase               <= lsfp_pkg::PH_IDLE;
      label_seen          <= 1'b0;
      label_code          <= lsfp_pkg::CH_TEMP;
      accumulator         <= '0;
      temperature_reading <= '0;
      humidity_reading    <= '0;
      pressure_reading    <= '0;
    end else if (step) begin
      phase               <= phase_next;
      label_seen          <= label_seen_next;
      label_code          <= label_code_next;
      accumulator         <= accumulator_next;
      temperature_reading <= temperature_reading_next;
      humidity_reading    <= humidity_reading_next;
      pressure_reading    <= pressure_reading_next;
    end
  end

endmodule

/* src/labelled_sensor_frame_parser_top.sv */
// Labelled sensor frame parser. Feed one ASCII byte per input transaction;
// frames look like '$', a label ('T', 'H' or 'P'), decimal digits, '#'. Each
// '#' that closes a frame with a label produces one output transaction
// carrying the channel (0 temperature, 1 humidity, 2 pressure), the frame's
// decimal value (saturated at 2^31-1) and all three held readings after the
// update; every other byte produces nothing. A '$' always restarts a frame.
// Throughput is one byte per clock unless stalled: a byte is captured in an
// input register, parsed by combinational logic (compare, multiply-by-ten
// add, saturate) and a completed frame's result lands in the output register.
// The input keeps flowing while a result waits, until a second result would
// need the occupied output register; then the parser stalls until that
// result is taken.
module labelled_sensor_frame_parser_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    rx_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    channel,
  output logic [lsfp_pkg::VAL_W-1:0]    frame_value,
  output logic [lsfp_pkg::VAL_W-1:0]    held_temperature,
  output logic [lsfp_pkg::VAL_W-1:0]    held_humidity,
  output logic [lsfp_pkg::VAL_W-1:0]    held_pressure
);

`include "labelled_sensor_frame_parser_top_assert.svh"

  // input register
  logic                  byte_full;
  logic [7:0]            byte_reg;

  lsfp_pkg::byte_class_t cls;
  lsfp_pkg::result_t     res;

  logic                  step;
  logic                  load_out;

  // Advance the parser when a byte is held, unless that byte closes a frame
  // while the output register is occupied and not draining, so a result can
  // never be overwritten.
  assign step     = byte_full && (!res.emit || !out_valid || out_ready);
  assign load_out = step && res.emit;
  assign in_ready = !byte_full || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_full <= 1'b0;
    end else if (in_ready) begin
      byte_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_reg <= rx_byte;
    end
  end

  lsfp_classify u_classify (
    .rx_byte (byte_reg),
    .cls     (cls)
  );

  lsfp_frame_fsm u_frame_fsm (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .cls  (cls),
    .res  (res)
  );

  // Output register: load on a finished frame, drop when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      channel          <= res.channel;
      frame_value      <= res.frame_value;
      held_temperature <= res.held_temperature;
      held_humidity    <= res.held_humidity;
      held_pressure    <= res.held_pressure;
    end
  end

  // A finished frame always shows up on the output in the next cycle.
  `LSFP_ASSERT(a_result_lands, load_out |=> out_valid)
  // Never parse into an occupied output register that is not draining.
  `LSFP_ASSERT(a_no_overwrite, (out_valid && !out_ready) |-> !load_out)
  // For the temperature channel, the held temperature equals the frame value.
  `LSFP_ASSERT(a_held_matches, (out_valid && channel == lsfp_pkg::CH_TEMP)
    |-> held_temperature == frame_value)
  // Reset leaves no result pending.
  `LSFP_ASSERT_ALWAYS(a_reset_clears, rst |=> !out_valid)

endmodule

/* tb/labelled_sensor_frame_parser_top_tb.sv */
`timescale 1ns / 100ps

module labelled_sensor_frame_parser_top_tb;
  import lsfp_pkg::*;

  localparam int RANDOM_BYTES = 1950;
  // Give up after this many cycles with no transaction on either side.
  localparam int QUIET_LIMIT  = 2000;
  // An accepted byte passes the input register, and its result the output
  // register, before it shows. Wait past that before the end check, so a late
  // stray result still shows up.
  localparam int DRAIN_CYCLES = 16;

  typedef struct {
    channel_t         channel;
    logic [VAL_W-1:0] frame_value;
    logic [VAL_W-1:0] held_temperature;
    logic [VAL_W-1:0] held_humidity;
    logic [VAL_W-1:0] held_pressure;
  } reading_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [7:0]       rx_byte = 8'h00;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [1:0]       channel;
  logic [VAL_W-1:0] frame_value;
  logic [VAL_W-1:0] held_temperature;
  logic [VAL_W-1:0] held_humidity;
  logic [VAL_W-1:0] held_pressure;

  logic [7:0] byte_queue[$];        // bytes still to send
  reading_t   pending_readings[$];  // frame results not yet received
  int         error_count = 0;
  int         quiet_cycles = 0;

  // Parser state as the testbench tracks it.
  phase_t           parse_phase = PH_IDLE;
  logic             label_taken = 1'b0;
  channel_t         label_ch = CH_TEMP;
  logic [VAL_W-1:0] digit_sum = '0;
  logic [VAL_W-1:0] temp_reading = '0;
  logic [VAL_W-1:0] humid_reading = '0;
  logic [VAL_W-1:0] press_reading = '0;

  labelled_sensor_frame_parser_top dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .rx_byte          (rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .channel          (channel),
    .frame_value      (frame_value),
    .held_temperature (held_temperature),
    .held_humidity    (held_humidity),
    .held_pressure    (held_pressure)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Advance the parser state by one byte; queue a reading when a labelled
  // frame closes.
  task automatic parse_byte(input logic [7:0] b);
    longint unsigned grown;
    reading_t        r;
    if (b == CHAR_DOLLAR) begin
      // A '$' restarts the frame from anywhere, dropping any partial one.
      parse_phase = PH_START;
      label_taken = 1'b0;
      label_ch    = CH_TEMP;
      digit_sum   = '0;
    end else if (b == CHAR_HASH) begin
      // A '#' with no label before it, or while idle, only returns to idle.
      if ((parse_phase == PH_START || parse_phase == PH_LABEL) && label_taken) begin
        case (label_ch)
          CH_TEMP:  temp_reading  = digit_sum;
          CH_HUMID: humid_reading = digit_sum;
          default:  press_reading = digit_sum;
        endcase
        r.channel          = label_ch;
        r.frame_value      = digit_sum;
        r.held_temperature = temp_reading;
        r.held_humidity    = humid_reading;
        r.held_pressure    = press_reading;
        pending_readings.push_back(r);
      end
      parse_phase = PH_IDLE;
    end else if (parse_phase == PH_START) begin
      if (b == CHAR_T || b == CHAR_H || b == CHAR_P) begin
        label_ch    = (b == CHAR_T) ? CH_TEMP : (b == CHAR_H) ? CH_HUMID : CH_PRESS;
        label_taken = 1'b1;
        parse_phase = PH_LABEL;
      end
    end else if (parse_phase == PH_LABEL && b >= CHAR_ZERO && b <= CHAR_NINE) begin
      // A second label after the first is not a digit, so it is ignored here.
      grown = longint'(digit_sum) * 10 + longint'(b - CHAR_ZERO);
      digit_sum = (grown > longint'(VAL_MAX)) ? VAL_MAX : grown[VAL_W-1:0];
    end
  endtask

  // Draw the idle cycles before the next transaction. Now and then hold a
  // stretch of back-to-back transactions.
  task automatic draw_wait(inout int calm_left, output int cycles);
    if (calm_left > 0) begin
      calm_left--;
      cycles = 0;
    end else if ($urandom_range(0, 24) == 0) begin
      calm_left = $urandom_range(20, 60);
      cycles = 0;
    end else begin
      cycles = $urandom_range(0, 17);
    end
  endtask

  task automatic check_field(input string name, input logic [VAL_W-1:0] want,
                             input logic [VAL_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  // Byte driver: present the next byte after a drawn number of idle cycles
  // and hold it until the transaction happens.
  always @(posedge clk) begin : byte_driver
    int send_wait;
    int send_calm;
    if (rst) begin
      in_valid  <= 1'b0;
      send_wait = 0;
      send_calm = 0;
    end else if (in_valid && in_ready) begin
      parse_byte(rx_byte);
      draw_wait(send_calm, send_wait);
      if (send_wait == 0 && byte_queue.size() > 0) begin
        rx_byte <= byte_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end else if (!in_valid) begin
      if (send_wait > 0) begin
        send_wait--;
      end else if (byte_queue.size() > 0) begin
        rx_byte  <= byte_queue.pop_front();
        in_valid <= 1'b1;
      end
    end
  end

  // Result monitor: compare each result transaction with the oldest pending
  // reading, then drop ready for a drawn number of cycles.
  always @(posedge clk) begin : result_monitor
    reading_t want;
    int       take_wait;
    int       take_calm;
    if (rst) begin
      out_ready <= 1'b0;
      take_wait = 0;
      take_calm = 0;
    end else if (out_valid && out_ready) begin
      if (pending_readings.size() == 0) begin
        $error("unexpected result: channel %0d, frame_value %0d", channel, frame_value);
        error_count++;
      end else begin
        want = pending_readings.pop_front();
        check_field("channel", VAL_W'(want.channel), VAL_W'(channel));
        check_field("frame_value", want.frame_value, frame_value);
        check_field("held_temperature", want.held_temperature, held_temperature);
        check_field("held_humidity", want.held_humidity, held_humidity);
        check_field("held_pressure", want.held_pressure, held_pressure);
      end
      draw_wait(take_calm, take_wait);
      out_ready <= (take_wait == 0);
    end else if (!out_ready) begin
      if (take_wait > 0)
        take_wait--;
      if (take_wait == 0)
        out_ready <= 1'b1;
    end
  end

  // Watchdog: count cycles without any transaction.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : stimulus
    logic [7:0] label_bytes[3];
    int         kind;
    int         digits;
    label_bytes = '{CHAR_T, CHAR_H, CHAR_P};

    // Directed part: '#' and a high byte while idle; a non-label byte and a
    // '#' before any label; a second label among the digits; a frame with a
    // label and no digits; a frame dropped by a new '$'; a saturating value.
    byte_queue = {CHAR_HASH, 8'hFF,
                  CHAR_DOLLAR, "X", CHAR_HASH,
                  CHAR_DOLLAR, CHAR_H, "9", CHAR_T, "7", CHAR_HASH,
                  CHAR_DOLLAR, CHAR_T, CHAR_HASH,
                  CHAR_DOLLAR, CHAR_H, "4", CHAR_DOLLAR, CHAR_P};
    repeat (10) byte_queue.push_back(CHAR_NINE);
    byte_queue.push_back(CHAR_HASH);

    // Random part: mostly well-formed frames with random content, with noise
    // between and inside frames, frames without a label and frames never
    // closed.
    while (byte_queue.size() < RANDOM_BYTES + 30) begin
      kind = $urandom_range(0, 19);
      if (kind < 3) begin
        repeat ($urandom_range(1, 4)) byte_queue.push_back(8'($urandom_range(0, 255)));
      end else begin
        byte_queue.push_back(CHAR_DOLLAR);
        if ($urandom_range(0, 7) == 0)
          byte_queue.push_back(8'($urandom_range(0, 255)));
        if (kind != 3)
          byte_queue.push_back(label_bytes[$urandom_range(0, 2)]);
        digits = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 6);
        repeat (digits) begin
          if ($urandom_range(0, 15) == 0)
            byte_queue.push_back(8'($urandom_range(0, 255)));
          byte_queue.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
        end
        if (kind != 4)
          byte_queue.push_back(CHAR_HASH);
      end
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Wait until every byte is sent and every reading has arrived.
    @(negedge clk);
    while (!(byte_queue.size() == 0 && !in_valid && pending_readings.size() == 0)
           && quiet_cycles < QUIET_LIMIT)
      @(negedge clk);

    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("labelled_sensor_frame_parser_top_tb: done, errors");
    end else begin
      repeat (DRAIN_CYCLES) @(negedge clk);
      if (error_count == 0 && pending_readings.size() == 0)
        $display("labelled_sensor_frame_parser_top_tb: done, clean");
      else
        $display("labelled_sensor_frame_parser_top_tb: done, errors");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/lsfp_pkg.sv
src/lsfp_classify.sv
src/lsfp_frame_fsm.sv
src/labelled_sensor_frame_parser_top.sv
tb/labelled_sensor_frame_parser_top_tb.sv
